// ===== rtl/core/nslt_pkg.sv =====
// Shared types, widths, register codes and helper functions for the node status link tracker.
// Has no dependencies; every module of the block imports it.
package nslt_pkg;

	localparam int InDataWidth   = 144;
	localparam int OutDataWidth  = 128;
	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth  = 16;
	localparam int TimeoutWidth  = 16;
	localparam int ConfirmWidth  = 4;

	localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd1500;
	localparam logic [ConfirmWidth-1:0] ConfirmReset = 4'd3;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_TIMEOUT = 2'd0,
		CFG_CONFIRM = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		LINK_NONE = 2'd0,
		LINK_DOWN = 2'd1,
		LINK_UP   = 2'd2
	} link_event_t;

	typedef struct packed {
		logic frame;
		logic tick;
	} step_t;

	typedef struct packed {
		logic [10:0] node_id;
		logic [15:0] speed_rpm;
		logic [15:0] setpoint_rpm;
		logic [4:0]  bus_volts;
		logic [7:0]  temperature;
		logic [3:0]  node_mode;
		logic [3:0]  fault_bits;
		logic [7:0]  sequence_number;
	} frame_t;

	// Exact for every byte value: floor(b * 205 / 2048) equals floor(b / 10) below 1029.
	function automatic logic [4:0] div10_byte(input logic [7:0] b);
		logic [15:0] prod;
		prod = {8'd0, b} * 16'd205;
		return prod[15:11];
	endfunction

endpackage

// ===== rtl/core/node_status_link_tracker_core.sv =====
// Node status link tracker: one input register, the update logic, and the state that doubles
// as the result register. Each item passes the input register, then the result register.
// Throughput is one item per cycle while results are taken; the output stage frees itself in the cycle it is taken.
// Reset clears all state but the input data, sets the node offline and loads the default timeout and confirm count.
// Depends on nslt_pkg, nslt_frame_decode, nslt_seq_tracker and nslt_link_monitor.
module node_status_link_tracker_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// frame_id, payload, now_ms, heartbeat_ms, zero fill
	input  logic [nslt_pkg::InDataWidth-1:0]      s_axis_tdata,
	// opcode
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// node_id, speed rpm, setpoint rpm, bus_volts, temperature, node_mode, fault nibble,
	// sequence_number, frame_count, missed frames, node_online, link_event, zero fill
	output logic [nslt_pkg::OutDataWidth-1:0]     m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [nslt_pkg::CfgIndexWidth-1:0]    cfg_index,
	input  logic [nslt_pkg::CfgDataWidth-1:0]     cfg_data
);
	import nslt_pkg::*;

	logic                    valid_s1;
	logic                    opcode_s1;
	logic [10:0]             frame_id_s1;
	logic [63:0]             payload_s1;
	logic [31:0]             now_s1;
	logic [31:0]             hb_s1;
	logic                    out_valid_q;
	logic [TimeoutWidth-1:0] timeout_q;
	logic [ConfirmWidth-1:0] confirm_q;
	frame_t                  last_frame_q;

	logic                    load;
	step_t                   step;
	frame_t                  decoded;
	logic                    unseed;
	logic                    node_online;
	link_event_t             link_event;
	logic [31:0]             frame_count;
	logic [15:0]             missed_count;

	assign cfg_ready     = 1'b1;
	assign load          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || load;
	assign step.frame    = load && !opcode_s1;
	assign step.tick     = load && opcode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
			confirm_q <= ConfirmReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_data[TimeoutWidth-1:0];
				CFG_CONFIRM: confirm_q <= cfg_data[ConfirmWidth-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1   <= s_axis_tuser;
			frame_id_s1 <= s_axis_tdata[10:0];
			payload_s1  <= s_axis_tdata[74:11];
			now_s1      <= s_axis_tdata[106:75];
			hb_s1       <= s_axis_tdata[138:107];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_frame_q <= '0;
		end else if (step.frame) begin
			last_frame_q <= decoded;
		end
	end

	nslt_frame_decode u_decode (
		.frame_id (frame_id_s1),
		.payload  (payload_s1),
		.fields   (decoded)
	);

	nslt_seq_tracker u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.sequence_number (decoded.sequence_number),
		.unseed          (unseed),
		.frame_count     (frame_count),
		.missed_count    (missed_count)
	);

	nslt_link_monitor u_link (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.now_ms        (now_s1),
		.heartbeat_ms  (hb_s1),
		.timeout       (timeout_q),
		.confirm_count (confirm_q),
		.node_online   (node_online),
		.link_event    (link_event),
		.went_offline  (unseed)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, link_event, node_online, missed_count, frame_count,
		last_frame_q.sequence_number, last_frame_q.fault_bits, last_frame_q.node_mode,
		last_frame_q.temperature, last_frame_q.bus_volts, last_frame_q.setpoint_rpm,
		last_frame_q.speed_rpm, last_frame_q.node_id};

`ifndef SYNTH
	a_up_means_online: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && link_event == LINK_UP) |-> node_online)
		else $error("Online event reported while the node is offline.");

	a_down_means_offline: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && link_event == LINK_DOWN) |-> !node_online)
		else $error("Offline event reported while the node is online.");

	a_frame_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		step.frame |=> (link_event == LINK_NONE && out_valid_q))
		else $error("A status frame produced a link event or no result.");

	a_online_stable_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		step.frame |=> $stable(node_online))
		else $error("A status frame changed the link state.");
`endif

endmodule

// ===== rtl/core/nslt_frame_decode.sv =====
// Unpacks the identifier and the eight data bytes of a status frame into named fields.
// Depends on nslt_pkg for the frame structure and the divide-by-ten helper.
module nslt_frame_decode (
	input  logic [10:0]       frame_id,
	input  logic [63:0]       payload,
	output nslt_pkg::frame_t  fields
);
	import nslt_pkg::*;

	always_comb begin
		fields.node_id         = frame_id;
		fields.speed_rpm       = payload[15:0];
		fields.setpoint_rpm    = payload[31:16];
		fields.bus_volts       = div10_byte(payload[39:32]);
		fields.temperature     = payload[47:40];
		fields.node_mode       = payload[51:48];
		fields.fault_bits      = payload[55:52];
		fields.sequence_number = payload[63:56];
	end

endmodule

// ===== rtl/core/nslt_seq_tracker.sv =====
// Counts status frames and frames lost to gaps in the modulo-256 sequence byte.
// Depends on nslt_pkg for the step control structure.
module nslt_seq_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  nslt_pkg::step_t     step,
	input  logic [7:0]          sequence_number,
	input  logic                unseed,
	output logic [31:0]         frame_count,
	output logic [15:0]         missed_count
);
	import nslt_pkg::*;

	logic [7:0]  prev_seq_q;
	logic        seeded_q;
	logic [31:0] frames_q;
	logic [15:0] lost_q;
	logic [7:0]  gap;

	assign gap = sequence_number - prev_seq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_seq_q <= '0;
			seeded_q   <= 1'b0;
			frames_q   <= '0;
			lost_q     <= '0;
		end else if (step.frame) begin
			frames_q <= frames_q + 32'd1;
			if (!seeded_q) begin
				prev_seq_q <= sequence_number;
				seeded_q   <= 1'b1;
			end else if (gap != 8'd0) begin
				if (gap > 8'd1) begin
					lost_q <= lost_q + {8'd0, gap} - 16'd1;
				end
				prev_seq_q <= sequence_number;
			end
		end else if (unseed) begin
			seeded_q <= 1'b0;
		end
	end

	assign frame_count  = frames_q;
	assign missed_count = lost_q;

endmodule

// ===== rtl/core/nslt_link_monitor.sv =====
// Heartbeat supervision: declares the node offline on timeout and online after fresh heartbeats.
// Depends on nslt_pkg for the step structure, the event codes and the register widths.
module nslt_link_monitor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  nslt_pkg::step_t                       step,
	input  logic [31:0]                           now_ms,
	input  logic [31:0]                           heartbeat_ms,
	input  logic [nslt_pkg::TimeoutWidth-1:0]     timeout,
	input  logic [nslt_pkg::ConfirmWidth-1:0]     confirm_count,
	output logic                                  node_online,
	output nslt_pkg::link_event_t                 link_event,
	output logic                                  went_offline
);
	import nslt_pkg::*;

	logic                    offline_q;
	logic [ConfirmWidth-1:0] cnt_q;
	logic [31:0]             prev_hb_q;
	link_event_t             event_q;

	logic [31:0]             age;
	logic [31:0]             spacing;
	logic                    timed_out;
	logic                    fresh;
	logic                    spaced_out;
	logic [ConfirmWidth-1:0] base;
	logic [ConfirmWidth-1:0] bumped;
	logic                    offline_d;
	logic [ConfirmWidth-1:0] cnt_d;
	link_event_t             event_d;

	always_comb begin
		age        = now_ms - heartbeat_ms;
		spacing    = heartbeat_ms - prev_hb_q;
		timed_out  = age >= {{(32-TimeoutWidth){1'b0}}, timeout};
		fresh      = offline_q && (heartbeat_ms != prev_hb_q);
		spaced_out = (prev_hb_q != 32'd0) &&
			(spacing >= {{(32-TimeoutWidth){1'b0}}, timeout});
		base       = spaced_out ? '0 : cnt_q;
		bumped     = (base < confirm_count) ? base + ConfirmWidth'(1) : base;
		offline_d  = offline_q;
		cnt_d      = cnt_q;
		event_d    = LINK_NONE;
		if (timed_out) begin
			cnt_d = '0;
			if (!offline_q) begin
				offline_d = 1'b1;
				event_d   = LINK_DOWN;
			end
		end else if (fresh) begin
			if (bumped >= confirm_count) begin
				offline_d = 1'b0;
				cnt_d     = '0;
				event_d   = LINK_UP;
			end else begin
				cnt_d = bumped;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offline_q <= 1'b1;
			cnt_q     <= '0;
			prev_hb_q <= '0;
			event_q   <= LINK_NONE;
		end else begin
			if (step.tick) begin
				offline_q <= offline_d;
				cnt_q     <= cnt_d;
				prev_hb_q <= heartbeat_ms;
				event_q   <= event_d;
			end else if (step.frame) begin
				event_q <= LINK_NONE;
			end
		end
	end

	assign went_offline = step.tick && timed_out && !offline_q;
	assign node_online  = !offline_q;
	assign link_event   = event_q;

endmodule
